### rtl/mrf_pkg.sv
// Package for the receive filter with neighbor cache.
// It holds the item types, the status codes, the table sizes and the register indexes.
// It depends on nothing else.
package mrf_pkg;

  localparam int NbrSlots   = 10;
  localparam int HistDepth  = 10;
  localparam int NbrIdxW    = (NbrSlots > 1) ? $clog2(NbrSlots) : 1;
  localparam int HistIdxW   = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int DivSteps   = 32;
  localparam int DivCntW    = $clog2(DivSteps);

  localparam logic [7:0] BeaconType    = 8'd4;
  localparam logic [7:0] EmptyAddr     = 8'd0;
  localparam logic [7:0] OwnAddrRst    = 8'd2;
  localparam logic [7:0] BcastAddrRst  = 8'd255;
  localparam logic [7:0] ExpLenRst     = 8'd206;

  localparam logic OpFrame = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [1:0] {
    CfgOwnAddr  = 2'd0,
    CfgBcastAddr = 2'd1,
    CfgExpLen   = 2'd2,
    CfgUnused   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StBadLen  = 3'd1,
    StBadCsum = 3'd2,
    StNotAddr = 3'd3,
    StDup     = 3'd4
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  frame_length;
    logic [15:0] frame_id;
    logic [7:0]  source;
    logic [7:0]  destination;
    logic [7:0]  frame_type;
    logic [7:0]  frame_checksum;
    logic [7:0]  payload_xor;
    logic [15:0] beacon_interval;
    logic [7:0]  query_node;
    logic [31:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        table_full;
    logic        neighbor_known;
    logic [15:0] wait_ticks;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [31:0] seen_at;
    logic [15:0] interval;
  } nbr_entry_t;

  localparam int NbrEntryW = $bits(nbr_entry_t);

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } mod_req_t;

endpackage

### rtl/mrf_if.sv
// Handshake interfaces for the input, result and configuration channels.
// They depend on mrf_pkg for the payload types.
interface mrf_in_if;
  logic              valid;
  logic              ready;
  mrf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrf_out_if;
  logic               valid;
  logic               ready;
  mrf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mrf_ram.sv
// Small synchronous RAM with one write and one registered read port.
// Entries never written read as zero; per-entry valid bits clear at reset.
module mrf_ram #(
  parameter int Depth = 10,
  parameter int Width = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rd_data_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // registered read, empty entries read as zero
  always_ff @(posedge clk_i) begin
    rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/mrf_mod_unit.sv
// Bit-serial remainder unit: 32-bit dividend modulo 16-bit divisor, one bit a cycle.
// It depends on mrf_pkg for the request type and step count.
module mrf_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrf_pkg::mod_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [15:0]       rem_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [mrf_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [31:0]                   dvd_q, dvd_d;
  logic [15:0]                   dvs_q, dvs_d;
  logic [15:0]                   rem_q, rem_d;
  logic [16:0]                   trial;
  logic [16:0]                   diff;

  // one restoring step
  always_comb begin
    trial = {rem_q, dvd_q[31]};
    diff  = trial - {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = diff[16] ? trial[15:0] : diff[15:0];
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mrf_pkg::DivCntW'(mrf_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### rtl/mac_receive_filter_neighbor_cache.sv
// Top level of the receive frame filter with neighbor wake-time cache.
// It depends on mrf_pkg, the interfaces in mrf_if, mrf_ram and mrf_mod_unit.
//
// Usage:
//   in_i   carries one transaction per frame (opcode 0) or wake-time query (opcode 1).
//   out_o  returns exactly one result transaction per input transaction, in order.
//   cfg_i  writes own address (0), broadcast address (1) and expected length (2);
//          other indexes are ignored. Write only while the block is idle.
// Sequencing:
//   One transaction is worked on at a time. A frame failing length or checksum
//   goes straight to the result state; a beacon scans the neighbor RAM with a
//   read state and a check state per slot, and the duplicate check scans the
//   history RAM with a read state and a check state per entry.
//   A query scans the neighbor RAM and, for a known neighbor with a nonzero
//   interval, then runs the 32-step serial remainder unit. Each scan step waits
//   for the registered RAM read.
// Reset: registers return to 2, 255 and 206; both RAMs read as all zero.
// Stall: a finished result sits in the output register; the next transaction is
//   taken meanwhile and waits at its end until that register frees.
module mac_receive_filter_neighbor_cache (
  input logic     clk_i,
  input logic     rst_ni,
  mrf_in_if.sink  in_i,
  mrf_out_if.source out_o,
  mrf_cfg_if.sink cfg_i
);

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SNbRd  = 8'b00000010,
    SNbChk = 8'b00000100,
    SHsRd  = 8'b00001000,
    SHsChk = 8'b00010000,
    SDiv   = 8'b00100000,
    SFin   = 8'b01000000,
    SSpare = 8'b10000000
  } state_e;

  state_e                         state_q, state_d;
  mrf_pkg::in_item_t              item_q, item_d;
  mrf_pkg::status_e               status_q, status_d;
  logic                           full_q, full_d;
  logic                           known_q, known_d;
  logic [15:0]                    wait_q, wait_d;
  logic [15:0]                    ivl_q, ivl_d;
  logic [mrf_pkg::NbrIdxW-1:0]    nidx_q, nidx_d;
  logic                           empty_q, empty_d;
  logic [mrf_pkg::NbrIdxW-1:0]    empty_idx_q, empty_idx_d;
  logic [mrf_pkg::HistIdxW-1:0]   hidx_q, hidx_d;
  logic [mrf_pkg::HistIdxW-1:0]   hwptr_q, hwptr_d;
  mrf_pkg::out_item_t             out_q, out_d;
  logic                           out_valid_q, out_valid_d;

  logic [7:0] own_addr_q, bcast_addr_q, exp_len_q;

  logic                           nb_wr_en;
  logic [mrf_pkg::NbrIdxW-1:0]    nb_wr_addr;
  mrf_pkg::nbr_entry_t            nb_wr_data;
  logic [mrf_pkg::NbrEntryW-1:0]  nb_rd_raw;
  mrf_pkg::nbr_entry_t            nb_entry;
  logic                           hs_wr_en;
  logic [15:0]                    hs_rd_data;
  mrf_pkg::mod_req_t              mod_req;
  logic                           mod_busy, mod_done;
  logic [15:0]                    mod_rem;

  logic       in_hs;
  logic [7:0] calc_csum;
  logic [7:0] target;
  logic       hit, cur_empty, eff_empty, nb_last, hs_last;
  logic [mrf_pkg::NbrIdxW-1:0] eff_empty_idx;
  logic       addressed;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= mrf_pkg::OwnAddrRst;
      bcast_addr_q <= mrf_pkg::BcastAddrRst;
      exp_len_q    <= mrf_pkg::ExpLenRst;
    end else if (cfg_i.valid) begin
      case (mrf_pkg::cfg_idx_e'(cfg_i.index))
        mrf_pkg::CfgOwnAddr:   own_addr_q   <= cfg_i.data;
        mrf_pkg::CfgBcastAddr: bcast_addr_q <= cfg_i.data;
        mrf_pkg::CfgExpLen:    exp_len_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // neighbor table RAM
  mrf_ram #(
    .Depth (mrf_pkg::NbrSlots),
    .Width (mrf_pkg::NbrEntryW)
  ) u_nbr_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (nb_wr_en),
    .wr_addr_i (nb_wr_addr),
    .wr_data_i (nb_wr_data),
    .rd_addr_i (nidx_q),
    .rd_data_o (nb_rd_raw)
  );
  assign nb_entry = mrf_pkg::nbr_entry_t'(nb_rd_raw);

  // frame id history RAM, used as a ring
  mrf_ram #(
    .Depth (mrf_pkg::HistDepth),
    .Width (16)
  ) u_hist_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (hs_wr_en),
    .wr_addr_i (hwptr_q),
    .wr_data_i (item_q.frame_id),
    .rd_addr_i (hidx_q),
    .rd_data_o (hs_rd_data)
  );

  // remainder unit for the wake-time query
  mrf_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .busy_o (mod_busy),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // handshake and per-item checks
  assign in_i.ready = (state_q == SIdle);
  assign in_hs      = in_i.valid && in_i.ready;
  assign calc_csum  = in_i.data.frame_id[7:0] ^ in_i.data.frame_id[15:8]
                    ^ in_i.data.source ^ in_i.data.destination
                    ^ in_i.data.frame_type ^ in_i.data.payload_xor;
  assign target     = (item_q.opcode == mrf_pkg::OpQuery) ? item_q.query_node : item_q.source;
  assign hit        = (nb_entry.addr == target);
  assign cur_empty  = (nb_entry.addr == mrf_pkg::EmptyAddr);
  assign eff_empty  = empty_q || cur_empty;
  assign eff_empty_idx = empty_q ? empty_idx_q : nidx_q;
  assign nb_last    = (nidx_q == mrf_pkg::NbrIdxW'(mrf_pkg::NbrSlots - 1));
  assign hs_last    = (hidx_q == mrf_pkg::HistIdxW'(mrf_pkg::HistDepth - 1));
  assign addressed  = (item_q.destination == own_addr_q)
                   || (item_q.destination == bcast_addr_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    status_d    = status_q;
    full_d      = full_q;
    known_d     = known_q;
    wait_d      = wait_q;
    ivl_d       = ivl_q;
    nidx_d      = nidx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    hidx_d      = hidx_q;
    hwptr_d     = hwptr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    nb_wr_en    = 1'b0;
    nb_wr_addr  = nidx_q;
    nb_wr_data  = '{addr: item_q.source, seen_at: item_q.now_ticks,
                    interval: item_q.beacon_interval};
    hs_wr_en    = 1'b0;
    mod_req     = '{start: 1'b0, dividend: item_q.now_ticks - nb_entry.seen_at,
                    divisor: nb_entry.interval};
    case (state_q)
      SIdle: begin
        if (in_hs) begin
          item_d   = in_i.data;
          status_d = mrf_pkg::StOk;
          full_d   = 1'b0;
          known_d  = 1'b0;
          wait_d   = '0;
          nidx_d   = '0;
          hidx_d   = '0;
          empty_d  = 1'b0;
          if (in_i.data.opcode == mrf_pkg::OpQuery) begin
            state_d = (in_i.data.query_node == mrf_pkg::EmptyAddr) ? SFin : SNbRd;
          end else if (in_i.data.frame_length != exp_len_q) begin
            status_d = mrf_pkg::StBadLen;
            state_d  = SFin;
          end else if (calc_csum != in_i.data.frame_checksum) begin
            status_d = mrf_pkg::StBadCsum;
            state_d  = SFin;
          end else if (in_i.data.frame_type == mrf_pkg::BeaconType) begin
            state_d = SNbRd;
          end else if ((in_i.data.destination != own_addr_q)
                    && (in_i.data.destination != bcast_addr_q)) begin
            status_d = mrf_pkg::StNotAddr;
            state_d  = SFin;
          end else begin
            state_d = SHsRd;
          end
        end
      end
      SNbRd: begin
        state_d = SNbChk;
      end
      SNbChk: begin
        if (cur_empty && !empty_q) begin
          empty_d     = 1'b1;
          empty_idx_d = nidx_q;
        end
        if (hit || nb_last) begin
          if (item_q.opcode == mrf_pkg::OpQuery) begin
            state_d = SFin;
            if (hit) begin
              known_d = 1'b1;
              ivl_d   = nb_entry.interval;
              if (nb_entry.interval != '0) begin
                mod_req.start = 1'b1;
                state_d       = SDiv;
              end
            end
          end else begin
            // beacon: refresh the matching slot, else claim the first empty one
            if (hit || eff_empty) begin
              nb_wr_en   = 1'b1;
              nb_wr_addr = hit ? nidx_q : eff_empty_idx;
            end else begin
              full_d = 1'b1;
            end
            if (addressed) begin
              state_d = SHsRd;
            end else begin
              status_d = mrf_pkg::StNotAddr;
              state_d  = SFin;
            end
          end
        end else begin
          nidx_d  = nidx_q + 1'b1;
          state_d = SNbRd;
        end
      end
      SHsRd: begin
        state_d = SHsChk;
      end
      SHsChk: begin
        if (hs_rd_data == item_q.frame_id) begin
          status_d = mrf_pkg::StDup;
          state_d  = SFin;
        end else if (hs_last) begin
          // new id overwrites the oldest entry
          hs_wr_en = 1'b1;
          hwptr_d  = (hwptr_q == mrf_pkg::HistIdxW'(mrf_pkg::HistDepth - 1))
                   ? '0 : hwptr_q + 1'b1;
          state_d  = SFin;
        end else begin
          hidx_d  = hidx_q + 1'b1;
          state_d = SHsRd;
        end
      end
      SDiv: begin
        if (mod_done) begin
          wait_d  = ivl_q - mod_rem;
          state_d = SFin;
        end
      end
      SFin: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = '{status: status_q, table_full: full_q,
                          neighbor_known: known_q, wait_ticks: wait_q};
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      hwptr_q     <= '0;
      empty_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hwptr_q     <= hwptr_d;
      empty_q     <= empty_d;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    status_q    <= status_d;
    full_q      <= full_d;
    known_q     <= known_d;
    wait_q      <= wait_d;
    ivl_q       <= ivl_d;
    nidx_q      <= nidx_d;
    empty_idx_q <= empty_idx_d;
    hidx_q      <= hidx_d;
    out_q       <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // a failed frame result never carries query fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != mrf_pkg::StOk)
      |-> (!out_q.neighbor_known && out_q.wait_ticks == '0))
    else $error("frame result carries query fields");

  // only one transaction in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs |=> !in_i.ready)
    else $error("input taken while busy");

  // remainder unit only started when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_req.start |-> !mod_busy)
    else $error("remainder unit started while busy");

endmodule
